>>> rtl/core/pdc_pkg.sv
`timescale 1ns / 1ps
// pdc_pkg: shared types and constants for the pid position/delta controller
// no dependencies; every other file refers to it by scoped names

package pdc_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_CALC  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_LOAD  = 2'd2
  } op_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 4'd0,
    REG_GAIN_P   = 4'd1,
    REG_GAIN_I   = 4'd2,
    REG_GAIN_D   = 4'd3,
    REG_INT_HI   = 4'd4,
    REG_INT_LO   = 4'd5,
    REG_DRIVE_HI = 4'd6,
    REG_DRIVE_LO = 4'd7
  } cfg_idx_t;

  // controller modes
  localparam logic MODE_POS = 1'b0;
  localparam logic MODE_INC = 1'b1;

  // scaled products saturate to +-(2^60 - 1)
  localparam int PROD_W = 61;
  // three products summed exactly
  localparam int SUM_W  = PROD_W + 2;
  // held output plus product sum
  localparam int ACC_W  = SUM_W + 1;

  // per-stage control travelling down the pipeline
  typedef struct packed {
    logic valid;
    op_t  op;
  } ctl_t;

endpackage

>>> rtl/core/pdc_if.sv
`timescale 1ns / 1ps
// pdc_if: valid/ready channel interfaces for item, result and config beats
// depends on pdc_pkg for the config index width

interface pdc_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] measurement;
  logic signed [DATA_WIDTH-1:0] integral_load;

  modport source (output valid, operation, setpoint, measurement, integral_load,
                  input ready);
  modport sink   (input valid, operation, setpoint, measurement, integral_load,
                  output ready);
endinterface

interface pdc_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic signed [DATA_WIDTH-1:0] current_error;

  modport source (output valid, drive, current_error, input ready);
  modport sink   (input valid, drive, current_error, output ready);
endinterface

interface pdc_cfg_if #(
  parameter int DATA_WIDTH = 32
);
  logic                             valid;
  logic                             ready;
  logic [pdc_pkg::CFG_IDX_W-1:0]    index;
  logic [DATA_WIDTH-1:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/pdc_cfg_regs.sv
`timescale 1ns / 1ps
// pdc_cfg_regs: mode, gain and limit registers written over the config channel
// depends on pdc_pkg and pdc_cfg_if

module pdc_cfg_regs #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pdc_cfg_if.sink                      cfg_bus,
  output logic                         mode,
  output logic signed [DATA_WIDTH-1:0] gain_p,
  output logic signed [DATA_WIDTH-1:0] gain_i,
  output logic signed [DATA_WIDTH-1:0] gain_d,
  output logic signed [DATA_WIDTH-1:0] integral_upper,
  output logic signed [DATA_WIDTH-1:0] integral_lower,
  output logic signed [DATA_WIDTH-1:0] drive_upper,
  output logic signed [DATA_WIDTH-1:0] drive_lower
);

  localparam logic [DATA_WIDTH-1:0] WMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] WMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                  mode_r;
  logic [DATA_WIDTH-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [DATA_WIDTH-1:0] int_hi_r, int_lo_r, drive_hi_r, drive_lo_r;

  // writes are always taken
  assign cfg_bus.ready = 1'b1;

  // register file, full-range limits after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= pdc_pkg::MODE_POS;
      gain_p_r   <= '0;
      gain_i_r   <= '0;
      gain_d_r   <= '0;
      int_hi_r   <= WMAX;
      int_lo_r   <= WMIN;
      drive_hi_r <= WMAX;
      drive_lo_r <= WMIN;
    end else if (cfg_bus.valid) begin
      unique case (pdc_pkg::cfg_idx_t'(cfg_bus.index))
        pdc_pkg::REG_MODE:     mode_r     <= cfg_bus.data[0];
        pdc_pkg::REG_GAIN_P:   gain_p_r   <= cfg_bus.data;
        pdc_pkg::REG_GAIN_I:   gain_i_r   <= cfg_bus.data;
        pdc_pkg::REG_GAIN_D:   gain_d_r   <= cfg_bus.data;
        pdc_pkg::REG_INT_HI:   int_hi_r   <= cfg_bus.data;
        pdc_pkg::REG_INT_LO:   int_lo_r   <= cfg_bus.data;
        pdc_pkg::REG_DRIVE_HI: drive_hi_r <= cfg_bus.data;
        pdc_pkg::REG_DRIVE_LO: drive_lo_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  assign mode           = mode_r;
  assign gain_p         = $signed(gain_p_r);
  assign gain_i         = $signed(gain_i_r);
  assign gain_d         = $signed(gain_d_r);
  assign integral_upper = $signed(int_hi_r);
  assign integral_lower = $signed(int_lo_r);
  assign drive_upper    = $signed(drive_hi_r);
  assign drive_lower    = $signed(drive_lo_r);

endmodule

>>> rtl/core/pdc_front.sv
`timescale 1ns / 1ps
// pdc_front: input register, error stage, integral and error history update
// depends on pdc_pkg and pdc_in_if; feeds the multiplier operands

module pdc_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pdc_in_if.sink                         in_bus,
  input  logic                           mode,
  input  logic signed [DATA_WIDTH-1:0]   integral_upper,
  input  logic signed [DATA_WIDTH-1:0]   integral_lower,
  input  logic                           dn_adv,
  output pdc_pkg::ctl_t                  ctl3,
  output logic signed [DATA_WIDTH-1:0]   err3,
  output logic signed [DATA_WIDTH+1:0]   xp3,
  output logic signed [DATA_WIDTH+1:0]   xi3,
  output logic signed [DATA_WIDTH+1:0]   xd3
);

  localparam int DW = DATA_WIDTH;
  localparam int XW = DATA_WIDTH + 2;

  // saturate a one-bit-grown sum back to the word
  function automatic logic signed [DW-1:0] sat_w(input logic signed [DW:0] v);
    logic signed [DW-1:0] r;
    if (v[DW] != v[DW-1]) r = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    else                  r = v[DW-1:0];
    return r;
  endfunction

  // upper limit checked first, lower limit wins
  function automatic logic signed [DW-1:0] clamp_w(input logic signed [DW-1:0] v,
                                                   input logic signed [DW-1:0] hi,
                                                   input logic signed [DW-1:0] lo);
    logic signed [DW-1:0] r;
    r = v;
    if (r >= hi) r = hi;
    if (r <= lo) r = lo;
    return r;
  endfunction

  pdc_pkg::ctl_t        ctl1_r, ctl2_r, ctl3_r;
  logic signed [DW-1:0] sp1_r, ms1_r, ld1_r;
  logic signed [DW-1:0] err2_r, ld2_r, err3_r;
  logic signed [XW-1:0] xp3_r, xi3_r, xd3_r;
  logic signed [DW-1:0] isum_r, last_r, older_r;
  logic signed [DW-1:0] isum_nxt, last_nxt, older_nxt;
  logic signed [XW-1:0] xp_nxt, xi_nxt, xd_nxt;
  logic signed [DW:0]   diff1, isum_add;
  logic signed [DW-1:0] err1, isum_pos;
  logic                 adv1, adv2, adv3, mv2;

  // stage advance chain, bubbles collapse
  assign adv3         = !ctl3_r.valid || dn_adv;
  assign adv2         = !ctl2_r.valid || adv3;
  assign adv1         = !ctl1_r.valid || adv2;
  assign mv2          = ctl2_r.valid && adv3;
  assign in_bus.ready = adv1;

  // error from the input register
  assign diff1 = (DW+1)'(sp1_r) - (DW+1)'(ms1_r);
  assign err1  = sat_w(diff1);

  // accumulated error for positional mode
  assign isum_add = (DW+1)'(isum_r) + (DW+1)'(err2_r);
  assign isum_pos = clamp_w(sat_w(isum_add), integral_upper, integral_lower);

  // state update and operand selection for the beat leaving stage 2
  always_comb begin
    isum_nxt  = isum_r;
    last_nxt  = last_r;
    older_nxt = older_r;
    xp_nxt    = XW'(err2_r);
    xi_nxt    = XW'(isum_pos);
    xd_nxt    = XW'(err2_r) - XW'(last_r);
    unique case (ctl2_r.op)
      pdc_pkg::OP_CALC: begin
        last_nxt = err2_r;
        if (mode == pdc_pkg::MODE_INC) begin
          older_nxt = last_r;
          xp_nxt    = XW'(err2_r) - XW'(last_r);
          xi_nxt    = XW'(err2_r);
          xd_nxt    = XW'(err2_r) - (XW'(last_r) <<< 1) + XW'(older_r);
        end else begin
          isum_nxt  = isum_pos;
        end
      end
      pdc_pkg::OP_CLEAR: begin
        isum_nxt  = '0;
        last_nxt  = '0;
        older_nxt = '0;
      end
      pdc_pkg::OP_LOAD: isum_nxt = ld2_r;
      default: ;
    endcase
  end

  // control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r  <= '0;
      ctl2_r  <= '0;
      ctl3_r  <= '0;
      isum_r  <= '0;
      last_r  <= '0;
      older_r <= '0;
    end else begin
      if (adv1) begin
        ctl1_r.valid <= in_bus.valid;
        ctl1_r.op    <= pdc_pkg::op_t'(in_bus.operation);
      end
      if (adv2) ctl2_r <= ctl1_r;
      if (adv3) ctl3_r <= ctl2_r;
      if (mv2) begin
        isum_r  <= isum_nxt;
        last_r  <= last_nxt;
        older_r <= older_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv1) begin
      sp1_r <= in_bus.setpoint;
      ms1_r <= in_bus.measurement;
      ld1_r <= in_bus.integral_load;
    end
    if (adv2) begin
      err2_r <= err1;
      ld2_r  <= ld1_r;
    end
    if (adv3) begin
      err3_r <= err2_r;
      xp3_r  <= xp_nxt;
      xi3_r  <= xi_nxt;
      xd3_r  <= xd_nxt;
    end
  end

  assign ctl3 = ctl3_r;
  assign err3 = err3_r;
  assign xp3  = xp3_r;
  assign xi3  = xi3_r;
  assign xd3  = xd3_r;

endmodule

>>> rtl/core/pdc_mult.sv
`timescale 1ns / 1ps
// pdc_mult: gain multipliers, fraction scaling with saturation, product sum
// depends on pdc_pkg; sits between pdc_front and pdc_drive

module pdc_mult #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pdc_pkg::ctl_t                        ctl3,
  input  logic signed [DATA_WIDTH-1:0]         err3,
  input  logic signed [DATA_WIDTH+1:0]         xp3,
  input  logic signed [DATA_WIDTH+1:0]         xi3,
  input  logic signed [DATA_WIDTH+1:0]         xd3,
  input  logic signed [DATA_WIDTH-1:0]         gain_p,
  input  logic signed [DATA_WIDTH-1:0]         gain_i,
  input  logic signed [DATA_WIDTH-1:0]         gain_d,
  input  logic                                 dn_adv,
  output logic                                 up_adv,
  output pdc_pkg::ctl_t                        ctl5,
  output logic signed [DATA_WIDTH-1:0]         err5,
  output logic signed [pdc_pkg::SUM_W-1:0]     sum5
);

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH + 2;
  localparam int QW = pdc_pkg::PROD_W;
  localparam int MW = (PW > QW + 1) ? PW : QW + 1;
  localparam int SW = pdc_pkg::SUM_W;

  // drop the fraction (floor) and saturate to +-(2^60 - 1)
  function automatic logic signed [QW-1:0] scale(input logic signed [PW-1:0] p);
    logic signed [MW-1:0] w;
    logic signed [MW-1:0] q;
    logic                 pos_ovf;
    logic                 neg_ovf;
    logic signed [QW-1:0] r;
    w       = MW'(p);
    q       = w >>> FRAC_BITS;
    pos_ovf = !q[MW-1] && (|q[MW-2:QW-1]);
    neg_ovf = q[MW-1] && (!(&q[MW-2:QW-1]) || (q[QW-2:0] == '0));
    if (pos_ovf)      r = {1'b0, {(QW-1){1'b1}}};
    else if (neg_ovf) r = {1'b1, {(QW-2){1'b0}}, 1'b1};
    else              r = q[QW-1:0];
    return r;
  endfunction

  pdc_pkg::ctl_t        ctl4_r, ctl5_r;
  logic signed [DW-1:0] err4_r, err5_r;
  logic signed [PW-1:0] pp4_r, pi4_r, pd4_r;
  logic signed [SW-1:0] sum5_r;
  logic signed [PW-1:0] pp, pi, pd;
  logic signed [QW-1:0] sp, si, sd;
  logic                 adv4, adv5;

  assign adv5   = !ctl5_r.valid || dn_adv;
  assign adv4   = !ctl4_r.valid || adv5;
  assign up_adv = adv4;

  // exact products
  assign pp = PW'(gain_p) * PW'(xp3);
  assign pi = PW'(gain_i) * PW'(xi3);
  assign pd = PW'(gain_d) * PW'(xd3);

  // scaled terms and their sum
  assign sp = scale(pp4_r);
  assign si = scale(pi4_r);
  assign sd = scale(pd4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
      ctl5_r <= '0;
    end else begin
      if (adv4) ctl4_r <= ctl3;
      if (adv5) ctl5_r <= ctl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      err4_r <= err3;
      pp4_r  <= pp;
      pi4_r  <= pi;
      pd4_r  <= pd;
    end
    if (adv5) begin
      err5_r <= err4_r;
      sum5_r <= SW'(sp) + SW'(si) + SW'(sd);
    end
  end

  assign ctl5 = ctl5_r;
  assign err5 = err5_r;
  assign sum5 = sum5_r;

endmodule

>>> rtl/core/pdc_drive.sv
`timescale 1ns / 1ps
// pdc_drive: held output update, output saturation and clamp, result register
// depends on pdc_pkg and pdc_out_if

module pdc_drive #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pdc_pkg::ctl_t                    ctl5,
  input  logic signed [DATA_WIDTH-1:0]     err5,
  input  logic signed [pdc_pkg::SUM_W-1:0] sum5,
  input  logic                             mode,
  input  logic signed [DATA_WIDTH-1:0]     drive_upper,
  input  logic signed [DATA_WIDTH-1:0]     drive_lower,
  output logic                             up_adv,
  pdc_out_if.source                        out_bus
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = pdc_pkg::ACC_W;

  logic                 out_valid_r;
  logic signed [DW-1:0] held_r, err_r;
  logic signed [DW-1:0] held_nxt, acc_sat, acc_clamp;
  logic signed [AW-1:0] acc;
  logic                 adv, mv;

  assign adv    = !out_valid_r || out_bus.ready;
  assign mv     = ctl5.valid && adv;
  assign up_adv = adv;

  // incremental mode builds on the held output
  assign acc = ((mode == pdc_pkg::MODE_INC) ? AW'(held_r) : AW'(0)) + AW'(sum5);

  // saturate to the word, then clamp (lower limit wins)
  always_comb begin
    if ((&acc[AW-1:DW-1]) || !(|acc[AW-1:DW-1])) acc_sat = acc[DW-1:0];
    else if (acc[AW-1]) acc_sat = {1'b1, {(DW-1){1'b0}}};
    else                acc_sat = {1'b0, {(DW-1){1'b1}}};
    acc_clamp = acc_sat;
    if (acc_clamp >= drive_upper) acc_clamp = drive_upper;
    if (acc_clamp <= drive_lower) acc_clamp = drive_lower;
  end

  // next held output per operation
  always_comb begin
    held_nxt = held_r;
    unique case (ctl5.op)
      pdc_pkg::OP_CALC:  held_nxt = acc_clamp;
      pdc_pkg::OP_CLEAR: held_nxt = '0;
      default: ;
    endcase
  end

  // held output doubles as the result drive register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      if (adv) out_valid_r <= ctl5.valid;
      if (mv)  held_r      <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv) err_r <= err5;
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.drive         = held_r;
  assign out_bus.current_error = err_r;

  // no result beat straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  // a clear beat leaves a zero drive
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    mv && ctl5.op == pdc_pkg::OP_CLEAR |=> held_r == '0)
    else $error("drive not zero after clear");

  // a compute beat lands inside ordered drive limits
  a_calc_limits: assert property (@(posedge clk) disable iff (!rst_n)
    mv && ctl5.op == pdc_pkg::OP_CALC && drive_lower <= drive_upper
    |=> held_r >= $past(drive_lower) && held_r <= $past(drive_upper))
    else $error("drive outside limits after compute");

  // the result register is loaded whenever a beat moves in
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mv |=> out_valid_r)
    else $error("beat moved in without result valid");

endmodule

>>> rtl/core/pid_position_delta_controller.sv
`timescale 1ns / 1ps
// pid_position_delta_controller: top level, positional or incremental fixed-point pid
// depends on pdc_pkg, pdc_if, pdc_cfg_regs, pdc_front, pdc_mult, pdc_drive
// throughput: one item per cycle while the result is taken; six register stages, one beat in each
// integral and error history close at stage 2, held drive at the output
// reset (rst_n low, synchronous) clears state and pipeline; limits go to full range

module pid_position_delta_controller #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pdc_in_if.sink    in_bus,
  pdc_out_if.source out_bus,
  pdc_cfg_if.sink   cfg_bus
);

  localparam int DW = DATA_WIDTH;

  logic                 mode;
  logic signed [DW-1:0] gain_p, gain_i, gain_d;
  logic signed [DW-1:0] integral_upper, integral_lower, drive_upper, drive_lower;

  pdc_pkg::ctl_t                    ctl3, ctl5;
  logic signed [DW-1:0]             err3, err5;
  logic signed [DW+1:0]             xp3, xi3, xd3;
  logic signed [pdc_pkg::SUM_W-1:0] sum5;
  logic                             mult_adv, drive_adv;

  // configuration registers
  pdc_cfg_regs #(.DATA_WIDTH(DW)) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_bus        (cfg_bus),
    .mode           (mode),
    .gain_p         (gain_p),
    .gain_i         (gain_i),
    .gain_d         (gain_d),
    .integral_upper (integral_upper),
    .integral_lower (integral_lower),
    .drive_upper    (drive_upper),
    .drive_lower    (drive_lower)
  );

  // input, error and state stages
  pdc_front #(.DATA_WIDTH(DW)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_bus         (in_bus),
    .mode           (mode),
    .integral_upper (integral_upper),
    .integral_lower (integral_lower),
    .dn_adv         (mult_adv),
    .ctl3           (ctl3),
    .err3           (err3),
    .xp3            (xp3),
    .xi3            (xi3),
    .xd3            (xd3)
  );

  // products and their sum
  pdc_mult #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl3   (ctl3),
    .err3   (err3),
    .xp3    (xp3),
    .xi3    (xi3),
    .xd3    (xd3),
    .gain_p (gain_p),
    .gain_i (gain_i),
    .gain_d (gain_d),
    .dn_adv (drive_adv),
    .up_adv (mult_adv),
    .ctl5   (ctl5),
    .err5   (err5),
    .sum5   (sum5)
  );

  // held output and result register
  pdc_drive #(.DATA_WIDTH(DW)) u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl5        (ctl5),
    .err5        (err5),
    .sum5        (sum5),
    .mode        (mode),
    .drive_upper (drive_upper),
    .drive_lower (drive_lower),
    .up_adv      (drive_adv),
    .out_bus     (out_bus)
  );

endmodule
